// ----- src/npcl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package npcl_pkg;
	localparam int PALETTE_ENTRIES = 255;
	localparam int PAL_AW = 8;
	localparam int GREEN_LEVELS = 256;
	localparam logic [10:0] DIST_START = 11'd1000;
	localparam logic [PAL_AW-1:0] LAST_POS = PAL_AW'(PALETTE_ENTRIES - 1);
	localparam logic [PAL_AW:0] N_POS = (PAL_AW+1)'(PALETTE_ENTRIES);

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_BUILD  = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// one palette entry: colour plus the slot it was loaded into
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] tag;
	} entry_t;

	// memory access request from the sequencer
	typedef struct packed {
		logic                pal_we;
		logic [PAL_AW-1:0]   pal_waddr;
		entry_t              pal_wdata;
		logic [PAL_AW-1:0]   pal_raddr;
		logic                tab_we;
		logic [7:0]          tab_waddr;
		logic [7:0]          tab_wdata;
		logic [7:0]          tab_raddr;
	} mem_req_t;

	function automatic logic [8:0] absdiff(input logic [7:0] a, input logic [7:0] c);
		return (a < c) ? {1'b0, c - a} : {1'b0, a - c};
	endfunction
endpackage
`default_nettype wire

// ----- src/npcl_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
module npcl_mem (
	input  wire logic               clk,
	input  wire npcl_pkg::mem_req_t req,
	output npcl_pkg::entry_t        pal_rdata,
	output logic [7:0]              tab_rdata
);
	import npcl_pkg::*;

	entry_t     pal_mem [PALETTE_ENTRIES];
	logic [7:0] tab_mem [GREEN_LEVELS];

	always_ff @(posedge clk) begin
		if (req.pal_we)
			pal_mem[req.pal_waddr] <= req.pal_wdata;
		pal_rdata <= pal_mem[req.pal_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.tab_we)
			tab_mem[req.tab_waddr] <= req.tab_wdata;
		tab_rdata <= tab_mem[req.tab_raddr];
	end
endmodule
`default_nettype wire

// ----- src/npcl_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
module npcl_seq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         opcode,
	input  wire logic [7:0]         entry_index,
	input  wire logic [7:0]         red,
	input  wire logic [7:0]         green,
	input  wire logic [7:0]         blue,
	output logic                    done,
	output logic [7:0]              palette_index,
	output npcl_pkg::mem_req_t      req,
	input  wire npcl_pkg::entry_t   pal_rdata,
	input  wire logic [7:0]         tab_rdata
);
	import npcl_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_SRD    = 12'b000000000010, // read entry i
		ST_SCAN   = 12'b000000000100, // scan k, track min
		ST_SWAPA  = 12'b000000001000, // write min entry to i
		ST_SWAPB  = 12'b000000010000, // write entry i to minpos
		ST_TAB    = 12'b000000100000, // table writes for new green
		ST_TEND   = 12'b000001000000, // tail of table
		ST_LTAB   = 12'b000010000000, // table read
		ST_LPICK  = 12'b000100000000, // choose next position
		ST_LWAIT  = 12'b001000000000, // palette read latency
		ST_LEVAL  = 12'b010000000000,
		ST_OUT    = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [PAL_AW:0] i_q, k_q, minpos_q, start_q, tk_q;
	logic [7:0] minval_q, prev_q;
	entry_t ei_q, emin_q;
	logic [7:0] r_q, g_q, b_q;
	logic [9:0] up_q, down_q; // signed-ish positions, down uses bit 9 as negative
	logic dir_q, cur_up_q;
	logic [10:0] bestd_q;
	logic [7:0] best_q;
	logic last_i;

	assign busy = (state_q != ST_IDLE);
	assign last_i = (i_q == N_POS - 1'b1);

	logic up_ok, dn_ok;
	assign up_ok = (up_q < {1'b0, N_POS});
	assign dn_ok = !down_q[9];

	logic [9:0] dg, dgb, dgbr;
	assign dg   = {1'b0, absdiff(pal_rdata.g, g_q)};
	assign dgb  = dg + {1'b0, absdiff(pal_rdata.b, b_q)};
	assign dgbr = dgb + {1'b0, absdiff(pal_rdata.r, r_q)};
	logic bound_hit;
	always_comb begin
		if (cur_up_q)
			bound_hit = (pal_rdata.g >= g_q) && ({2'b0, pal_rdata.g - g_q} >= bestd_q);
		else
			bound_hit = (g_q >= pal_rdata.g) && ({2'b0, g_q - pal_rdata.g} >= bestd_q);
	end

	always_comb begin
		req = '0;
		unique case (state_q)
			ST_IDLE: begin
				req.pal_we    = start && opcode == OP_LOAD && entry_index < N_POS[7:0]
					&& N_POS > 9'(entry_index);
				req.pal_waddr = entry_index;
				req.pal_wdata = '{r: red, g: green, b: blue, tag: entry_index};
				req.tab_raddr = green;
				req.pal_raddr = '0;
			end
			ST_SRD:   req.pal_raddr = i_q[7:0];
			ST_SCAN:  req.pal_raddr = k_q[7:0];
			ST_SWAPA: begin
				req.pal_we = (minpos_q != i_q);
				req.pal_waddr = i_q[7:0];
				req.pal_wdata = emin_q;
			end
			ST_SWAPB: begin
				req.pal_we = (minpos_q != i_q);
				req.pal_waddr = minpos_q[7:0];
				req.pal_wdata = ei_q;
			end
			ST_TAB: begin
				req.tab_we = 1'b1;
				req.tab_waddr = tk_q[7:0];
				req.tab_wdata = (tk_q[7:0] == prev_q) ? 8'((start_q + i_q) >> 1) : i_q[7:0];
			end
			ST_TEND: begin
				req.tab_we = 1'b1;
				req.tab_waddr = tk_q[7:0];
				req.tab_wdata = (tk_q[7:0] == prev_q) ? 8'((start_q + {1'b0, LAST_POS}) >> 1)
					: LAST_POS;
			end
			ST_LPICK: req.pal_raddr = (dir_q && up_ok) || !dn_ok ? up_q[7:0] : down_q[7:0];
			// hold the address so the entry is still on the read port in eval
			ST_LWAIT: req.pal_raddr = cur_up_q ? up_q[7:0] : down_q[7:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (start) begin
					r_q <= red; g_q <= green; b_q <= blue;
					if (opcode == OP_BUILD) begin
						i_q <= '0; prev_q <= '0; start_q <= '0;
						state_q <= ST_SRD;
					end else if (opcode == OP_LOOKUP)
						state_q <= ST_LTAB;
				end
				ST_SRD: begin
					k_q <= i_q + 1'b1;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// data for previous read address arrives now
					if (k_q == i_q + 1'b1) begin
						ei_q <= pal_rdata; emin_q <= pal_rdata;
						minval_q <= pal_rdata.g; minpos_q <= i_q;
					end else if (pal_rdata.g < minval_q) begin
						emin_q <= pal_rdata; minval_q <= pal_rdata.g; minpos_q <= k_q - 1'b1;
					end
					if (k_q == N_POS) state_q <= ST_SWAPA;
					else k_q <= k_q + 1'b1;
				end
				ST_SWAPA: state_q <= ST_SWAPB;
				ST_SWAPB: begin
					if (minval_q != prev_q) begin
						tk_q <= {1'b0, prev_q};
						state_q <= ST_TAB;
					end else if (last_i) begin
						tk_q <= {1'b0, prev_q};
						state_q <= ST_TEND;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= ST_SRD;
					end
				end
				ST_TAB: begin
					if (tk_q[7:0] + 9'd1 >= {1'b0, minval_q}) begin
						prev_q <= minval_q;
						start_q <= i_q;
						if (last_i) begin
							tk_q <= {1'b0, minval_q};
							state_q <= ST_TEND;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= ST_SRD;
						end
					end else tk_q <= tk_q + 1'b1;
				end
				ST_TEND: begin
					if (tk_q == 9'd255) state_q <= ST_IDLE;
					else tk_q <= tk_q + 1'b1;
				end
				ST_LTAB: begin
					up_q <= {2'b0, tab_rdata};
					down_q <= {2'b0, tab_rdata} - 10'd1;
					if ({1'b0, tab_rdata} > LAST_POS + 9'd1) begin
						up_q <= {1'b0, N_POS};
						down_q <= {1'b0, N_POS} - 10'd1;
					end
					bestd_q <= DIST_START; best_q <= '0; dir_q <= 1'b1;
					state_q <= ST_LPICK;
				end
				ST_LPICK: begin
					if (!up_ok && !dn_ok) state_q <= ST_OUT;
					else begin
						cur_up_q <= (dir_q && up_ok) || !dn_ok;
						state_q <= ST_LWAIT;
					end
				end
				ST_LWAIT: state_q <= ST_LEVAL;
				ST_LEVAL: begin
					if (cur_up_q) begin
						up_q <= bound_hit ? {1'b0, N_POS} : up_q + 10'd1;
						dir_q <= 1'b0;
					end else begin
						down_q <= bound_hit ? 10'h3FF : down_q - 10'd1;
						dir_q <= 1'b1;
					end
					if (!bound_hit && {1'b0, dgbr} < bestd_q && {1'b0, dgb} < bestd_q) begin
						bestd_q <= {1'b0, dgbr};
						best_q <= pal_rdata.tag;
					end
					state_q <= ST_LPICK;
				end
				ST_OUT: begin
					done <= 1'b1;
					palette_index <= best_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- src/nearest_palette_color_lookup_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// nearest palette color lookup
// command channel: start/busy with opcode, entry_index, red, green, blue;
// a transfer happens when start is high and busy is low
// opcode load writes one palette slot, build selection-sorts the palette by
// green and fills the green start table, lookup searches outward
// from the table position and returns the nearest slot on palette_index,
// marked by done for one cycle
// build's scan loop is paced by the single palette memory read port; lookup
// passes through the pick, wait and eval states for each examined entry
// one command at a time; busy stays high until the result is given
// reset puts the sequencer idle; memories hold no defined value until written
// the receiver cannot stall: a result is shown exactly once
module nearest_palette_color_lookup_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] entry_index,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic            done,
	output logic [7:0]      palette_index
);
	import npcl_pkg::*;

	mem_req_t   req;
	entry_t     pal_rdata;
	logic [7:0] tab_rdata;

	npcl_seq u_seq (
		.clk, .arst_n, .start, .busy, .opcode, .entry_index, .red, .green, .blue,
		.done, .palette_index, .req, .pal_rdata, .tab_rdata
	);

	npcl_mem u_mem (.clk, .req, .pal_rdata, .tab_rdata);
endmodule
`default_nettype wire

// ----- tb/tb_nearest_palette_color_lookup_top.sv -----
`timescale 1ns / 1ps
module tb_nearest_palette_color_lookup_top;
	import npcl_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [1:0] opcode = OP_NONE;
	logic [7:0] entry_index = '0;
	logic [7:0] red = '0;
	logic [7:0] green = '0;
	logic [7:0] blue = '0;
	wire        busy;
	wire        done;
	wire  [7:0] palette_index;

	nearest_palette_color_lookup_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .entry_index(entry_index), .red(red), .green(green),
		.blue(blue), .done(done), .palette_index(palette_index)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// own copy of the palette store and the green start table
	logic [7:0] pal_red [0:255];
	logic [7:0] pal_green [0:255];
	logic [7:0] pal_blue [0:255];
	logic [7:0] pal_slot [0:255];
	logic [7:0] green_start [0:255];

	logic [7:0] nearest_q[$];   // expected slot per accepted lookup
	int         errors = 0;
	int         idle_pct = 0;   // chance in percent that the sender idles after a transfer

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	// selection sort by green, then fill the start position per green level
	function automatic void sort_palette_by_green();
		int n;
		int prev;
		int first;
		int minpos;
		int minval;
		logic [7:0] t;
		n = PALETTE_ENTRIES;
		prev = 0;
		first = 0;
		for (int i = 0; i < n; i++) begin
			minpos = i;
			minval = pal_green[i];
			for (int k = i + 1; k < n; k++) begin
				if (pal_green[k] < minval) begin
					minpos = k;
					minval = pal_green[k];
				end
			end
			if (minpos != i) begin
				t = pal_red[i];   pal_red[i] = pal_red[minpos];     pal_red[minpos] = t;
				t = pal_green[i]; pal_green[i] = pal_green[minpos]; pal_green[minpos] = t;
				t = pal_blue[i];  pal_blue[i] = pal_blue[minpos];   pal_blue[minpos] = t;
				t = pal_slot[i];  pal_slot[i] = pal_slot[minpos];   pal_slot[minpos] = t;
			end
			if (minval != prev) begin
				green_start[prev & 255] = 8'((first + i) >> 1);
				for (int k = prev + 1; k < minval; k++)
					green_start[k & 255] = 8'(i);
				prev = minval;
				first = i;
			end
		end
		green_start[prev & 255] = 8'((first + n - 1) >> 1);
		for (int k = prev + 1; k < GREEN_LEVELS; k++)
			green_start[k] = 8'(n - 1);
	endfunction

	function automatic int dist_abs(input int a, input int c);
		return (a < c) ? c - a : a - c;
	endfunction

	// outward search, alternating up and down, strict-less-than wins
	function automatic logic [7:0] nearest_slot(input int r, input int g, input int b);
		int n;
		int bestd;
		int best;
		int up;
		int down;
		int d;
		int pos;
		n = PALETTE_ENTRIES;
		bestd = 1000;
		best = 0;
		up = green_start[g];
		down = up - 1;
		if (up >= n) up = n;
		if (down >= n) down = n - 1;
		while (up < n || down >= 0) begin
			for (int side = 0; side < 2; side++) begin
				pos = side ? down : up;
				if (side == 0 && up < n) begin
					if (int'(pal_green[up]) - g >= bestd) begin
						up = n;
						pos = -1;
					end else
						up++;
				end else if (side == 1 && down >= 0) begin
					if (g - int'(pal_green[down]) >= bestd) begin
						down = -1;
						pos = -1;
					end else
						down--;
				end else
					pos = -1;
				if (pos >= 0) begin
					d = dist_abs(pal_green[pos], g) + dist_abs(pal_blue[pos], b);
					if (d < bestd) begin
						d += dist_abs(pal_red[pos], r);
						if (d < bestd) begin
							bestd = d;
							best = pal_slot[pos];
						end
					end
				end
			end
		end
		return 8'(best);
	endfunction

	// one command transfer; called right after a rising edge
	task automatic send_command(input logic [1:0] op, input logic [7:0] slot,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		start <= 1'b1;
		opcode <= op;
		entry_index <= slot;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (busy);
		// transfer taken at this edge: update the prediction
		case (op)
			OP_LOAD: begin
				if (slot < PALETTE_ENTRIES) begin
					pal_red[slot] = r;
					pal_green[slot] = g;
					pal_blue[slot] = b;
					pal_slot[slot] = slot;
				end
			end
			OP_BUILD: sort_palette_by_green();
			OP_LOOKUP: nearest_q.push_back(nearest_slot(r, g, b));
			default: ;
		endcase
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			opcode <= 2'($urandom);
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// sender holds off until every lookup has answered
	task automatic drain_results();
		start <= 1'b0;
		while (nearest_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// each done cycle is one result transfer
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (nearest_q.size() == 0) begin
				report_mismatch("unexpected result, palette_index", palette_index, -1);
			end else begin
				if (palette_index !== nearest_q[0])
					report_mismatch("palette_index", palette_index, nearest_q[0]);
				void'(nearest_q.pop_front());
			end
		end
	end

	// every slot written so that builds never touch undefined entries;
	// extremes at the ends, ignored slot and unused opcode too
	task automatic test_fill_palette();
		send_command(OP_LOAD, 8'd0, 8'd0, 8'd0, 8'd0);
		for (int s = 1; s < PALETTE_ENTRIES - 1; s++)
			send_command(OP_LOAD, 8'(s), 8'($urandom), 8'($urandom), 8'($urandom));
		send_command(OP_LOAD, 8'd254, 8'd255, 8'd255, 8'd255);
		send_command(OP_LOAD, 8'd255, 8'd17, 8'd99, 8'd201);
		send_command(OP_NONE, 8'hff, 8'hff, 8'hff, 8'hff);
	endtask

	task automatic test_directed_lookups();
		send_command(OP_BUILD, 8'd0, 8'd0, 8'd0, 8'd0);
		send_command(OP_LOOKUP, 8'd0, 8'd0, 8'd0, 8'd0);
		send_command(OP_LOOKUP, 8'hff, 8'd255, 8'd255, 8'd255);
		send_command(OP_LOOKUP, 8'd0, 8'd255, 8'd0, 8'd255);
		send_command(OP_LOOKUP, 8'd0, 8'd0, 8'd255, 8'd0);
		send_command(OP_LOOKUP, 8'd0, 8'd128, 8'd128, 8'd128);
		send_command(OP_NONE, 8'd3, 8'd1, 8'd2, 8'd3);
		// equal greens in several slots: tie goes to the first found
		send_command(OP_LOAD, 8'd10, 8'd40, 8'd77, 8'd40);
		send_command(OP_LOAD, 8'd20, 8'd40, 8'd77, 8'd40);
		send_command(OP_LOAD, 8'd30, 8'd41, 8'd77, 8'd39);
		// load after build, then lookups on the half-updated store
		send_command(OP_LOOKUP, 8'd0, 8'd40, 8'd77, 8'd40);
		send_command(OP_LOOKUP, 8'd0, 8'd200, 8'd3, 8'd9);
		send_command(OP_BUILD, 8'd0, 8'd0, 8'd0, 8'd0);
		send_command(OP_LOOKUP, 8'd0, 8'd40, 8'd77, 8'd40);
		send_command(OP_LOOKUP, 8'd0, 8'd41, 8'd77, 8'd39);
		send_command(OP_LOAD, 8'd255, 8'd40, 8'd77, 8'd40);
		send_command(OP_LOOKUP, 8'd0, 8'd40, 8'd77, 8'd40);
		drain_results();
	endtask

	// mostly lookups; narrow green spread gives many ties and long walks
	task automatic test_random_mix(input int count, input bit narrow);
		int pick;
		logic [7:0] g;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			g = narrow ? 8'($urandom_range(100, 108)) : 8'($urandom);
			if (pick < 78)
				send_command(OP_LOOKUP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			else if (pick < 95)
				send_command(OP_LOAD, 8'($urandom), 8'($urandom), g, 8'($urandom));
			else if (pick < 97)
				send_command(OP_BUILD, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			else
				send_command(OP_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		end
		send_command(OP_BUILD, 8'd0, 8'd0, 8'd0, 8'd0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_palette();
		test_directed_lookups();
		idle_pct = 21;
		test_random_mix(90, 1'b0);
		drain_results();
		idle_pct = 65;
		test_random_mix(90, 1'b1);
		idle_pct = 0;
		test_random_mix(95, 1'b0);
		start <= 1'b0;
		while (nearest_q.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// generous fixed limit on the run
	initial begin
		#120000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
